@@ rtl/tan_pkg.sv @@
package tan_pkg;

    // Port widths.
    localparam int IN_W     = 16;
    localparam int AREA_W   = 34;
    localparam int NRM_W    = 16;

    // Used bits of each coordinate.
    localparam int COORD_WIDTH = 16;

    // Fraction bits of a normal component.
    localparam int FRAC_W   = 14;

    // Derived datapath widths.
    localparam int E_W      = COORD_WIDTH + 1;     // edge vector component
    localparam int P_W      = 2 * E_W;             // edge product
    localparam int C_W      = P_W + 1;             // cross product component
    localparam int M_W      = C_W - 1;             // cross product magnitude
    localparam int H_W      = (M_W + 1) / 2;       // low half of the magnitude
    localparam int PP_W     = 2 * H_W;             // partial square
    localparam int S_W      = 2 * M_W;             // squared length
    localparam int A_W      = S_W / 2;             // root of the squared length
    localparam int A_REM_W  = A_W + 2;
    localparam int Q_W      = 2 * FRAC_W + 1;      // squared normal quotient
    localparam int U_W      = FRAC_W + 1;          // normal magnitude
    localparam int U_SH_W   = 2 * U_W;
    localparam int U_REM_W  = U_W + 2;
    localparam int CMP_W    = (A_W > AREA_W) ? A_W : AREA_W;

    // Pipeline depths.
    localparam int A_STEPS  = A_W;
    localparam int D_STEPS  = Q_W;
    localparam int BK_DEPTH = (A_STEPS > D_STEPS + U_W) ? A_STEPS : D_STEPS + U_W;
    localparam int FR_DEPTH = 7;
    localparam int LAT      = FR_DEPTH + BK_DEPTH + 1;

    typedef struct packed {
        logic [S_W-1:0]     d_rem;
        logic [Q_W-1:0]     d_quo;
        logic               d_low;
        logic [U_SH_W-1:0]  u_sh;
        logic [U_REM_W-1:0] u_rem;
        logic [U_W-1:0]     u_root;
        logic               neg;
    } t_cmp;

    typedef struct packed {
        logic [S_W-1:0]     s_sh;
        logic [S_W-1:0]     s;
        logic [A_REM_W-1:0] a_rem;
        logic [A_W-1:0]     a_root;
        t_cmp [2:0]         cmp;
        logic               degen;
    } t_bk;

    // One digit step of every unit. The area root runs over the first A_STEPS
    // stages. Each component first divides its square (scaled by 2^(2*FRAC_W))
    // by the squared length, then takes the root of that quotient.
    function automatic t_bk f_step(input t_bk x, input int k);
        t_bk                y;
        logic [A_REM_W+1:0] a_cur;
        logic [A_REM_W+1:0] a_try;
        logic [S_W:0]       d_cur;
        logic [U_REM_W+1:0] u_cur;
        logic [U_REM_W+1:0] u_try;
        logic [U_SH_W-1:0]  u_sh;
        logic [U_REM_W-1:0] u_rem;
        logic [U_W-1:0]     u_root;
        y = x;
        if (k < A_STEPS) begin
            a_cur = {x.a_rem, x.s_sh[S_W-1 -: 2]};
            a_try = {2'b00, x.a_root, 2'b01};
            if (a_cur >= a_try) begin
                y.a_rem  = A_REM_W'(a_cur - a_try);
                y.a_root = {x.a_root[A_W-2:0], 1'b1};
            end else begin
                y.a_rem  = a_cur[A_REM_W-1:0];
                y.a_root = {x.a_root[A_W-2:0], 1'b0};
            end
            y.s_sh = {x.s_sh[S_W-3:0], 2'b00};
        end
        for (int j = 0; j < 3; j++) begin
            if (k < D_STEPS) begin
                // Only the first step brings in a nonzero dividend bit.
                d_cur = {x.cmp[j].d_rem, (k == 0) ? x.cmp[j].d_low : 1'b0};
                if (d_cur >= {1'b0, x.s}) begin
                    y.cmp[j].d_rem = S_W'(d_cur - {1'b0, x.s});
                    y.cmp[j].d_quo = {x.cmp[j].d_quo[Q_W-2:0], 1'b1};
                end else begin
                    y.cmp[j].d_rem = d_cur[S_W-1:0];
                    y.cmp[j].d_quo = {x.cmp[j].d_quo[Q_W-2:0], 1'b0};
                end
            end else if (k < D_STEPS + U_W) begin
                if (k == D_STEPS) begin
                    u_sh   = U_SH_W'(x.cmp[j].d_quo);
                    u_rem  = '0;
                    u_root = '0;
                end else begin
                    u_sh   = x.cmp[j].u_sh;
                    u_rem  = x.cmp[j].u_rem;
                    u_root = x.cmp[j].u_root;
                end
                u_cur = {u_rem, u_sh[U_SH_W-1 -: 2]};
                u_try = {2'b00, u_root, 2'b01};
                if (u_cur >= u_try) begin
                    y.cmp[j].u_rem  = U_REM_W'(u_cur - u_try);
                    y.cmp[j].u_root = {u_root[U_W-2:0], 1'b1};
                end else begin
                    y.cmp[j].u_rem  = u_cur[U_REM_W-1:0];
                    y.cmp[j].u_root = {u_root[U_W-2:0], 1'b0};
                end
                y.cmp[j].u_sh = {u_sh[U_SH_W-3:0], 2'b00};
            end
        end
        return y;
    endfunction

endpackage

@@ rtl/tan_digits.sv @@
module tan_digits (
    input  logic          i_clk,
    input  logic          i_en,
    input  tan_pkg::t_bk  i_bk,
    output tan_pkg::t_bk  o_bk
);
    import tan_pkg::*;

    t_bk r_st [BK_DEPTH];

    for (genvar k = 0; k < BK_DEPTH; k++) begin : g_stage
        t_bk w_prev;
        if (k == 0) begin : g_first
            assign w_prev = i_bk;
        end else begin : g_next
            assign w_prev = r_st[k-1];
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_st[k] <= f_step(w_prev, k);
            end
        end
    end

    assign o_bk = r_st[BK_DEPTH-1];

endmodule

@@ rtl/triangle_area_and_unit_normal_core.sv @@
// Channel   Valid     Stall     Payload
// input     i_valid   o_stall   i_v0_x .. i_v2_z  (signed Q12.4)
// output    o_valid   i_stall   o_area, o_normal_x/y/z, o_degenerate
//
// A new triangle is accepted every cycle unless o_stall is raised.
// The latency is set by the digit pipelines: seven front stages, then one stage
// per root or quotient bit, then an output register.
// Reset clears only the valid bits. While a result waits under i_stall, the
// whole pipeline holds and o_stall is raised.
module triangle_area_and_unit_normal_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v0_x,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v0_y,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v0_z,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v1_x,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v1_y,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v1_z,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v2_x,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v2_y,
    input  logic signed [tan_pkg::IN_W-1:0]   i_v2_z,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [tan_pkg::AREA_W-1:0]        o_area,
    output logic signed [tan_pkg::NRM_W-1:0]  o_normal_x,
    output logic signed [tan_pkg::NRM_W-1:0]  o_normal_y,
    output logic signed [tan_pkg::NRM_W-1:0]  o_normal_z,
    output logic                              o_degenerate
);
    import tan_pkg::*;

    logic                w_en;
    logic [LAT-1:0]      r_vld;

    logic [IN_W-1:0]     w_v0 [3];
    logic [IN_W-1:0]     w_v1 [3];
    logic [IN_W-1:0]     w_v2 [3];

    logic signed [E_W-1:0] r_e1 [3];
    logic signed [E_W-1:0] r_e2 [3];
    logic signed [P_W-1:0] r_p  [6];
    logic signed [C_W-1:0] r_c  [3];
    logic [M_W-1:0]        r_mag [3];
    logic [PP_W-1:0]       r_hh [3];
    logic [PP_W-1:0]       r_hl [3];
    logic [PP_W-1:0]       r_ll [3];
    logic [S_W-1:0]        r_sq [3];
    logic [2:0]            r_neg4;
    logic [2:0]            r_neg5;
    logic [2:0]            r_neg6;
    logic [S_W-1:0]        w_sum;
    t_bk                   r_bk0;
    t_bk                   n_bk0;
    t_bk                   w_bk_out;

    logic [A_W-1:0]        w_half;
    logic [AREA_W-1:0]     n_area;
    logic signed [NRM_W-1:0] n_nrm [3];
    logic [AREA_W-1:0]     r_area;
    logic signed [NRM_W-1:0] r_nrm [3];
    logic                  r_degen;

    function automatic logic signed [E_W-1:0] f_sx(input logic [IN_W-1:0] v);
        return E_W'(signed'(v[COORD_WIDTH-1:0]));
    endfunction

    // The pipeline only holds when a finished result is refused.
    assign w_en    = !(r_vld[LAT-1] && i_stall);
    assign o_stall = r_vld[LAT-1] && i_stall;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    assign w_v0[0] = i_v0_x;
    assign w_v0[1] = i_v0_y;
    assign w_v0[2] = i_v0_z;
    assign w_v1[0] = i_v1_x;
    assign w_v1[1] = i_v1_y;
    assign w_v1[2] = i_v1_z;
    assign w_v2[0] = i_v2_x;
    assign w_v2[1] = i_v2_y;
    assign w_v2[2] = i_v2_z;

    assign w_sum = r_sq[0] + r_sq[1] + r_sq[2];

    always_comb begin
        n_bk0        = '0;
        n_bk0.s_sh   = w_sum;
        n_bk0.s      = w_sum;
        n_bk0.degen  = (w_sum == '0);
        for (int j = 0; j < 3; j++) begin
            n_bk0.cmp[j].d_rem = r_sq[j] >> 1;
            n_bk0.cmp[j].d_low = r_sq[j][0];
            n_bk0.cmp[j].neg   = r_neg6[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int j = 0; j < 3; j++) begin
                r_e1[j] <= f_sx(w_v1[j]) - f_sx(w_v0[j]);
                r_e2[j] <= f_sx(w_v2[j]) - f_sx(w_v1[j]);
            end
            r_p[0] <= r_e1[1] * r_e2[2];
            r_p[1] <= r_e1[2] * r_e2[1];
            r_p[2] <= r_e1[2] * r_e2[0];
            r_p[3] <= r_e1[0] * r_e2[2];
            r_p[4] <= r_e1[0] * r_e2[1];
            r_p[5] <= r_e1[1] * r_e2[0];
            for (int j = 0; j < 3; j++) begin
                r_c[j]    <= C_W'(r_p[2*j]) - C_W'(r_p[2*j+1]);
                r_neg4[j] <= r_c[j][C_W-1];
                r_mag[j]  <= M_W'(r_c[j][C_W-1] ? -r_c[j] : r_c[j]);
                // Square of the magnitude from three narrow partial products.
                r_hh[j]   <= PP_W'(r_mag[j][M_W-1:H_W]) * PP_W'(r_mag[j][M_W-1:H_W]);
                r_hl[j]   <= PP_W'(r_mag[j][M_W-1:H_W]) * PP_W'(r_mag[j][H_W-1:0]);
                r_ll[j]   <= PP_W'(r_mag[j][H_W-1:0]) * PP_W'(r_mag[j][H_W-1:0]);
                r_sq[j]   <= (S_W'(r_hh[j]) << (2 * H_W)) + (S_W'(r_hl[j]) << (H_W + 1))
                             + S_W'(r_ll[j]);
            end
            r_neg5 <= r_neg4;
            r_neg6 <= r_neg5;
            r_bk0  <= n_bk0;
        end
    end

    tan_digits u_digits (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_bk  (r_bk0),
        .o_bk  (w_bk_out)
    );

    assign w_half = w_bk_out.a_root >> 1;

    always_comb begin
        if (CMP_W'(w_half) > CMP_W'({AREA_W{1'b1}})) begin
            n_area = {AREA_W{1'b1}};
        end else begin
            n_area = AREA_W'(w_half);
        end
        for (int j = 0; j < 3; j++) begin
            n_nrm[j] = w_bk_out.cmp[j].neg ? -NRM_W'(w_bk_out.cmp[j].u_root)
                                           : NRM_W'(w_bk_out.cmp[j].u_root);
        end
        if (w_bk_out.degen) begin
            n_area = '0;
            for (int j = 0; j < 3; j++) begin
                n_nrm[j] = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_area  <= n_area;
            r_nrm   <= n_nrm;
            r_degen <= w_bk_out.degen;
        end
    end

    assign o_area       = r_area;
    assign o_normal_x   = r_nrm[0];
    assign o_normal_y   = r_nrm[1];
    assign o_normal_z   = r_nrm[2];
    assign o_degenerate = r_degen;

endmodule
